[rtl/core/integer_to_ascii_radix_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII radix unit
// Checks are compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define ITOA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itoa check failed");
// next-cycle implication, sampled on clk, off during reset
`define ITOA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itoa check failed");
`else
`define ITOA_ASSERT_NOW(lbl, ante, cons)
`define ITOA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/core/itoa_pkg.sv]
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and helpers of the integer to ASCII radix unit.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 8;

    // divider retires this many quotient bits per cycle
    localparam int BITS_PER_CYCLE = 8;
    localparam int DIV_CYCLES     = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
    localparam int PAD_W          = DIV_CYCLES * BITS_PER_CYCLE;
    localparam int STEP_W         = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    // digit stack
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W = $clog2(VALUE_WIDTH);

    // queue between front and back, depth a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 8'h7a;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] mag;
        logic                   neg;
        logic [RADIX_W-1:0]     radix;
    } itoa_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } itoa_q_status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d < DEC_DIGITS)
        begin
            return CHAR_ZERO + d_ext;
        end
        return CHAR_LOW_A + d_ext - CHAR_W'(DEC_DIGITS);
    endfunction

endpackage

[rtl/core/itoa_ifs.sv]
// ----------------------------------------------------------------------------
// itoa channel interfaces
// Operand, text and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface itoa_in_if;
    logic                             valid;
    logic                             ready;
    logic [itoa_pkg::VALUE_WIDTH-1:0] value;
    logic                             is_signed;

    modport source (output valid, output value, output is_signed, input ready);
    modport sink   (input valid, input value, input is_signed, output ready);
endinterface

interface itoa_out_if;
    logic                        valid;
    logic                        ready;
    logic [itoa_pkg::CHAR_W-1:0] character;
    logic                        last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

interface itoa_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [itoa_pkg::RADIX_W-1:0] radix;

    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

[rtl/core/integer_to_ascii_radix_unit.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_unit
// Converts 32-bit operands to ASCII text in a programmable radix.
// ----------------------------------------------------------------------------
// Each operand is taken with a signed flag and returned as a stream of ASCII
// characters, one per item, most significant digit first, lowercase letters
// for digits above nine, a leading '-' for negative signed operands, and
// last set on the final character. The radix register (reset 10) clamps
// values below 2 to 2 and above 36 to 36; write it only while the unit is
// idle. A two-entry queue sits between the input classifier and the digit
// generator, so operands are accepted while an earlier one is converted.
// In the digit generator, each digit of an operand comes from a restoring
// divider that retires 8 quotient bits per cycle; the characters (one per
// digit, plus one for a sign) then follow one per cycle while text is ready.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_radix_unit_defines.svh"

module integer_to_ascii_radix_unit (
    input  logic       clk,
    input  logic       rst_n,
    itoa_in_if.sink    operand,
    itoa_out_if.source text,
    itoa_cfg_if.sink   cfg
);

    logic                     push_valid;
    logic                     push_ready;
    itoa_pkg::itoa_item_t     push_item;
    logic                     pop_valid;
    logic                     pop_ready;
    itoa_pkg::itoa_item_t     pop_item;
    itoa_pkg::itoa_q_status_t q_status;

    itoa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .operand    (operand),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    itoa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .status     (q_status)
    );

    itoa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .text      (text)
    );

    `ITOA_ASSERT_NOW(a_accept_not_full, operand.valid && operand.ready, !q_status.full)
    `ITOA_ASSERT_NEXT(a_accept_queued, operand.valid && operand.ready, !q_status.empty)
    `ITOA_ASSERT_NOW(a_minus_not_last, text.valid && (text.character == itoa_pkg::CHAR_MINUS), !text.last)
    `ITOA_ASSERT_NOW(a_legal_char, text.valid, (text.character == itoa_pkg::CHAR_MINUS) || ((text.character >= itoa_pkg::CHAR_ZERO) && (text.character <= itoa_pkg::CHAR_NINE)) || ((text.character >= itoa_pkg::CHAR_LOW_A) && (text.character <= itoa_pkg::CHAR_LOW_Z)))

endmodule

[rtl/core/itoa_front.sv]
// ----------------------------------------------------------------------------
// itoa_front
// Holds the radix register, takes operands, forms sign and magnitude.
// ----------------------------------------------------------------------------
module itoa_front (
    input  logic                 clk,
    input  logic                 rst_n,
    itoa_in_if.sink              operand,
    itoa_cfg_if.sink             cfg,
    output logic                 push_valid,
    input  logic                 push_ready,
    output itoa_pkg::itoa_item_t push_item
);

    logic [itoa_pkg::RADIX_W-1:0]     radix_reg;
    logic [itoa_pkg::RADIX_W-1:0]     radix_next;
    logic [itoa_pkg::RADIX_W-1:0]     radix_eff;
    logic                             neg;
    logic [itoa_pkg::VALUE_WIDTH-1:0] mag;

    always_comb
    begin
        radix_next = radix_reg;
        if (cfg.valid)
        begin
            radix_next = cfg.radix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= itoa_pkg::RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    assign cfg.ready = 1'b1;

    always_comb
    begin
        radix_eff = radix_reg;
        if (radix_reg < itoa_pkg::RADIX_MIN)
        begin
            radix_eff = itoa_pkg::RADIX_MIN;
        end
        else if (radix_reg > itoa_pkg::RADIX_MAX)
        begin
            radix_eff = itoa_pkg::RADIX_MAX;
        end
    end

    // most negative value negates to itself, which is the right magnitude
    assign neg = operand.is_signed & operand.value[itoa_pkg::VALUE_WIDTH-1];
    assign mag = neg ? (~operand.value + 1'b1) : operand.value;

    assign push_valid      = operand.valid;
    assign operand.ready   = push_ready;
    assign push_item.mag   = mag;
    assign push_item.neg   = neg;
    assign push_item.radix = radix_eff;

endmodule

[rtl/core/itoa_queue.sv]
// ----------------------------------------------------------------------------
// itoa_queue
// Short FIFO of classified operands between front and back.
// ----------------------------------------------------------------------------
module itoa_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push_valid,
    output logic                     push_ready,
    input  itoa_pkg::itoa_item_t     push_item,
    output logic                     pop_valid,
    input  logic                     pop_ready,
    output itoa_pkg::itoa_item_t     pop_item,
    output itoa_pkg::itoa_q_status_t status
);

    itoa_pkg::itoa_item_t             entry_reg [itoa_pkg::Q_DEPTH];
    logic [itoa_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [itoa_pkg::Q_PTR_W-1:0]     wr_ptr_next;
    logic [itoa_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [itoa_pkg::Q_PTR_W-1:0]     rd_ptr_next;
    logic [itoa_pkg::Q_CNT_W-1:0]     count_reg;
    logic [itoa_pkg::Q_CNT_W-1:0]     count_next;
    logic                             do_push;
    logic                             do_pop;

    assign status.full  = (count_reg == itoa_pkg::Q_CNT_W'(itoa_pkg::Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign push_ready   = !status.full;
    assign pop_valid    = !status.empty;
    assign do_push      = push_valid && push_ready;
    assign do_pop       = pop_valid && pop_ready;
    assign pop_item     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/core/itoa_back.sv]
// ----------------------------------------------------------------------------
// itoa_back
// Digit generator: repeated division by the radix into a digit stack,
// then emission of sign and digits, most significant first.
// ----------------------------------------------------------------------------
module itoa_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  itoa_pkg::itoa_item_t pop_item,
    itoa_out_if.source           text
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } back_state_t;

    back_state_t                      state_reg;
    back_state_t                      state_next;
    logic [itoa_pkg::PAD_W-1:0]       quo_reg;
    logic [itoa_pkg::PAD_W-1:0]       quo_next;
    logic [itoa_pkg::RADIX_W-1:0]     rem_reg;
    logic [itoa_pkg::RADIX_W-1:0]     rem_next;
    logic [itoa_pkg::RADIX_W-1:0]     radix_reg;
    logic [itoa_pkg::RADIX_W-1:0]     radix_next;
    logic                             neg_reg;
    logic                             neg_next;
    logic                             sign_pend_reg;
    logic                             sign_pend_next;
    logic [itoa_pkg::STEP_W-1:0]      step_reg;
    logic [itoa_pkg::STEP_W-1:0]      step_next;
    logic [itoa_pkg::CNT_W-1:0]       cnt_reg;
    logic [itoa_pkg::CNT_W-1:0]       cnt_next;
    logic [itoa_pkg::RADIX_W-1:0]     digit_reg [itoa_pkg::VALUE_WIDTH];
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [itoa_pkg::CHAR_W-1:0]      out_char_reg;
    logic [itoa_pkg::CHAR_W-1:0]      out_char_next;
    logic                             out_last_reg;
    logic                             out_last_next;

    logic [itoa_pkg::PAD_W-1:0]       div_quo;
    logic [itoa_pkg::RADIX_W-1:0]     div_rem;
    logic                             digit_done;
    logic                             push_digit;
    logic                             load_ok;
    logic [itoa_pkg::CNT_W-1:0]       cnt_m1;
    logic [itoa_pkg::IDX_W-1:0]       top_idx;

    // restoring division, BITS_PER_CYCLE quotient bits per cycle
    always_comb
    begin
        logic [itoa_pkg::RADIX_W:0] trial;
        div_quo = quo_reg;
        div_rem = rem_reg;
        for (int i = 0; i < itoa_pkg::BITS_PER_CYCLE; i++)
        begin
            trial   = {div_rem, div_quo[itoa_pkg::PAD_W-1]};
            div_quo = {div_quo[itoa_pkg::PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, radix_reg})
            begin
                div_rem    = itoa_pkg::RADIX_W'(trial - {1'b0, radix_reg});
                div_quo[0] = 1'b1;
            end
            else
            begin
                div_rem = trial[itoa_pkg::RADIX_W-1:0];
            end
        end
    end

    assign digit_done = (step_reg == itoa_pkg::STEP_W'(itoa_pkg::DIV_CYCLES - 1));
    assign push_digit = (state_reg == ST_DIV) && digit_done;
    assign load_ok    = !out_valid_reg || text.ready;
    assign cnt_m1     = cnt_reg - 1'b1;
    assign top_idx    = cnt_m1[itoa_pkg::IDX_W-1:0];
    assign pop_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        radix_next     = radix_reg;
        neg_next       = neg_reg;
        sign_pend_next = sign_pend_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (load_ok)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    quo_next   = itoa_pkg::PAD_W'(pop_item.mag);
                    rem_next   = '0;
                    radix_next = pop_item.radix;
                    neg_next   = pop_item.neg;
                    step_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next  = div_quo;
                rem_next  = div_rem;
                step_next = step_reg + 1'b1;
                if (digit_done)
                begin
                    step_next = '0;
                    rem_next  = '0;
                    cnt_next  = cnt_reg + 1'b1;
                    if (div_quo == '0)
                    begin
                        sign_pend_next = neg_reg;
                        state_next     = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    if (sign_pend_reg)
                    begin
                        out_char_next  = itoa_pkg::CHAR_MINUS;
                        out_last_next  = 1'b0;
                        sign_pend_next = 1'b0;
                    end
                    else
                    begin
                        out_char_next = itoa_pkg::digit_char(digit_reg[top_idx]);
                        out_last_next = (cnt_reg == itoa_pkg::CNT_W'(1));
                        cnt_next      = cnt_m1;
                        if (cnt_reg == itoa_pkg::CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            cnt_reg       <= '0;
            sign_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            sign_pend_reg <= sign_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        radix_reg    <= radix_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        if (push_digit)
        begin
            digit_reg[cnt_reg[itoa_pkg::IDX_W-1:0]] <= div_rem;
        end
    end

    assign text.valid     = out_valid_reg;
    assign text.character = out_char_reg;
    assign text.last      = out_last_reg;

endmodule
